[rtl/svp_pkg.sv]
// svp_pkg: shared types and constants of the stepper valve positioner
// coil sequence table, configuration register indexes and field widths
// no dependencies
package svp_pkg;

    localparam int unsigned CFG_INDEX_W   = 3;
    localparam int unsigned CFG_DATA_W    = 10;
    localparam int unsigned RESET_STEPS_W = 10;
    localparam int unsigned TIMER_W       = 8;
    localparam int unsigned COIL_W        = 4;
    localparam int unsigned PHASE_W       = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE         = 3'd0,
        REG_REVERSE_WIRING = 3'd1,
        REG_STEP_PERIOD    = 3'd2,
        REG_START_HOLD     = 3'd3,
        REG_STOP_HOLD      = 3'd4,
        REG_CLOSE_EXTRA    = 3'd5,
        REG_RESET_STEPS    = 3'd6
    } cfg_reg_t;

    typedef logic [COIL_W-1:0] coil_t;

    // half-step sequence, coils A..D in bits 0..3
    localparam coil_t COIL_SEQ [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8, 4'h9
    };

    localparam logic [PHASE_W-1:0] PHASE_HOME = 3'd7;
    localparam logic [TIMER_W-1:0] TIMER_MAX  = 8'hff;

    // reversed wiring walks the same table from the far end
    function automatic coil_t coil_lookup(input logic [PHASE_W-1:0] phase,
                                          input logic                reversed);
        logic [PHASE_W-1:0] idx;
        idx = reversed ? (PHASE_HOME - phase) : phase;
        return COIL_SEQ[idx];
    endfunction

endpackage

[rtl/stepper_valve_positioner_top.sv]
// stepper_valve_positioner_top: half-step unipolar stepper positioner for an expansion valve
// uses svp_pkg for the coil table and register indexes
//
// Usage:
//   s_ channel: one request per 1 ms tick. s_tdata carries the target opening,
//   s_tuser the init flag that, while enabled, homes the valve (position and step count set to
//   reset_steps, phase 7, closing, start hold armed).
//   m_ channel: one result per request: coil drive, tracked position, moving
//   flag and direction, taken after the request has updated the state.
//   cfg channel: register index and write data, always ready; the user must write it
//   only while no request is in flight, which the block itself does not enforce.
//   Path: an accepted request is loaded into the input register, and its result
//   into the result register once that register can advance.
//   Throughput: one request per cycle unless m_tready stalls the result; the whole
//   tick update is a single pass of adders and compares between input and result registers.
//   Reset: state cleared, phase 7, coils off, registers at their defaults,
//   both channels empty.
//   Stall: while m_tready is low the result holds, one more request waits in
//   the input register, and then s_tready drops.
module stepper_valve_positioner_top
    import svp_pkg::*;
#(
    parameter int unsigned POS_BITS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((POS_BITS+7)/8)*8-1:0] s_tdata,   // target_position
    input  logic                          s_tuser,   // init_request
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // coil_drive, position, moving, direction
    output logic [((COIL_W+POS_BITS+2+7)/8)*8-1:0] m_tdata,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

    localparam int unsigned P      = POS_BITS;
    localparam int unsigned RES_W  = COIL_W + P + 2;
    localparam int unsigned OUT_W  = ((RES_W + 7) / 8) * 8;
    localparam int unsigned RS_EXT = (P > RESET_STEPS_W) ? P : RESET_STEPS_W;
    localparam logic [P:0]  POS_MAX = {1'b0, {P{1'b1}}};

    // configuration registers
    logic                     enable_reg;
    logic                     reverse_reg;
    logic [TIMER_W-1:0]       step_period_reg;
    logic [TIMER_W-1:0]       start_hold_reg;
    logic [TIMER_W-1:0]       stop_hold_reg;
    logic [TIMER_W-1:0]       close_extra_reg;
    logic [RESET_STEPS_W-1:0] reset_steps_reg;

    // input register
    logic         in_valid_reg;
    logic         in_init_reg;
    logic [P-1:0] in_target_reg;

    // valve state
    logic [P-1:0]       cur_reg,   cur_next;
    logic [P-1:0]       rem_reg,   rem_next;
    logic [P-1:0]       lt_reg,    lt_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               dir_reg,   dir_next;
    logic [TIMER_W-1:0] pt_reg,    pt_next;
    logic [TIMER_W-1:0] hold_reg,  hold_next;
    coil_t              coil_reg,  coil_next;

    // result register
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic advance;
    logic fire;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b0;
            reverse_reg     <= 1'b0;
            step_period_reg <= 8'd32;
            start_hold_reg  <= 8'd50;
            stop_hold_reg   <= 8'd50;
            close_extra_reg <= 8'd160;
            reset_steps_reg <= 10'd560;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ENABLE:         enable_reg      <= cfg_wdata[0];
                REG_REVERSE_WIRING: reverse_reg     <= cfg_wdata[0];
                REG_STEP_PERIOD:    step_period_reg <= cfg_wdata[TIMER_W-1:0];
                REG_START_HOLD:     start_hold_reg  <= cfg_wdata[TIMER_W-1:0];
                REG_STOP_HOLD:      stop_hold_reg   <= cfg_wdata[TIMER_W-1:0];
                REG_CLOSE_EXTRA:    close_extra_reg <= cfg_wdata[TIMER_W-1:0];
                REG_RESET_STEPS:    reset_steps_reg <= cfg_wdata[RESET_STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_init_reg   <= s_tuser;
            in_target_reg <= s_tdata[P-1:0];
        end
    end

    // tick update
    logic [RS_EXT-1:0]  rs_ext;
    logic [P-1:0]       rs_pos;
    logic [TIMER_W-1:0] pt_inc;
    logic [TIMER_W-1:0] hold_dec;
    logic [P-1:0]       rem_dec;
    logic [P-1:0]       cur_plan;
    logic [P:0]         close_sum;

    always_comb begin
        rs_ext    = RS_EXT'(reset_steps_reg);
        rs_pos    = rs_ext[P-1:0];
        pt_inc    = (pt_reg != TIMER_MAX) ? pt_reg + 8'd1 : pt_reg;
        hold_dec  = (hold_reg != '0) ? hold_reg - 8'd1 : hold_reg;
        rem_dec   = rem_reg - P'(1);
        close_sum = {1'b0, cur_reg} + (P+1)'(close_extra_reg);
        cur_plan  = cur_reg;

        cur_next   = cur_reg;
        rem_next   = rem_reg;
        lt_next    = lt_reg;
        phase_next = phase_reg;
        dir_next   = dir_reg;
        pt_next    = pt_reg;
        hold_next  = hold_reg;
        coil_next  = coil_reg;

        if (enable_reg) begin
            if (in_init_reg) begin
                coil_next  = '0;
                pt_next    = step_period_reg;
                rem_next   = rs_pos;
                cur_next   = rs_pos;
                lt_next    = '0;
                phase_next = PHASE_HOME;
                dir_next   = 1'b0;
                hold_next  = start_hold_reg;
            end else begin
                pt_next   = pt_inc;
                hold_next = hold_dec;
                if (pt_inc >= step_period_reg) begin
                    pt_next = '0;
                    if (rem_reg != '0) begin
                        if (hold_dec == '0) begin
                            if (dir_reg) begin
                                cur_next   = cur_reg + P'(1);
                                phase_next = phase_reg + 3'd1;
                            end else begin
                                cur_next   = cur_reg - P'(1);
                                phase_next = phase_reg - 3'd1;
                            end
                            rem_next = rem_dec;
                            if (rem_dec == '0) begin
                                hold_next = stop_hold_reg;
                            end
                        end
                        coil_next = coil_lookup(phase_next, reverse_reg);
                    end else begin
                        if (hold_dec == '0) begin
                            coil_next = '0;
                            lt_next   = in_target_reg;
                        end
                        // plan a move towards the latched target
                        if (cur_reg != lt_next) begin
                            hold_next = start_hold_reg;
                            // closing fully overdrives against the end stop
                            if (lt_next == '0 && cur_reg != '0) begin
                                cur_plan = (close_sum > POS_MAX) ? POS_MAX[P-1:0]
                                                                 : close_sum[P-1:0];
                            end
                            cur_next = cur_plan;
                            if (cur_plan < lt_next) begin
                                rem_next = lt_next - cur_plan;
                                dir_next = 1'b1;
                            end else begin
                                rem_next = cur_plan - lt_next;
                                dir_next = 1'b0;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg   <= '0;
            rem_reg   <= '0;
            lt_reg    <= '0;
            phase_reg <= PHASE_HOME;
            dir_reg   <= 1'b0;
            pt_reg    <= '0;
            hold_reg  <= '0;
            coil_reg  <= '0;
        end else if (fire) begin
            cur_reg   <= cur_next;
            rem_reg   <= rem_next;
            lt_reg    <= lt_next;
            phase_reg <= phase_next;
            dir_reg   <= dir_next;
            pt_reg    <= pt_next;
            hold_reg  <= hold_next;
            coil_reg  <= coil_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= OUT_W'({dir_next, (rem_next != '0), cur_next, coil_next});
        end
    end

endmodule
